// File: hw/rtl/glk_pkg.sv
// Shared types and constants of the glyph lookup and kerning block.
// Depends on nothing; every other file of the block but glk_ram imports it.
package glk_pkg;

    localparam int GLYPH_ENTRIES = 256;
    localparam int KERN_ENTRIES  = 1024;

    localparam int GAW = (GLYPH_ENTRIES > 1) ? $clog2(GLYPH_ENTRIES) : 1;
    localparam int KAW = (KERN_ENTRIES > 1) ? $clog2(KERN_ENTRIES) : 1;

    // Counter width: holds num_glyphs, any 11-bit glyph and GLYPH_ENTRIES up to 2048.
    localparam int CNT_W = 12;

    localparam logic [15:0] TOP_BITS = 16'hF800;
    localparam logic [15:0] LIST_END = 16'hFFFF;

    localparam logic [1:0] MODE_GLYPH = 2'd0;
    localparam logic [1:0] MODE_KERN  = 2'd1;
    localparam logic [1:0] MODE_TEXT  = 2'd2;
    localparam logic [1:0] MODE_NONE  = 2'd3;

    typedef struct packed {
        logic [1:0]         mode;
        logic [9:0]         entry_index;
        logic [15:0]        char_code;
        logic [15:0]        glyph_width;
        logic [15:0]        kern_list_start;
        logic [15:0]        pair_first;
        logic [15:0]        pair_second;
        logic signed [15:0] pair_adjust;
        logic               string_start;
    } t_in_item;

    typedef struct packed {
        logic [15:0]        glyph_id;
        logic [15:0]        advance;
        logic signed [15:0] kern_adjust;
    } t_out_item;

    typedef struct packed {
        logic [15:0] code;
        logic [15:0] width;
        logic [15:0] kstart;
    } t_glyph_ent;

    typedef struct packed {
        logic [15:0]        first;
        logic [15:0]        second;
        logic signed [15:0] adjust;
    } t_kern_ent;

    typedef struct packed {
        logic           we;
        logic [GAW-1:0] waddr;
        t_glyph_ent     wdata;
        logic [GAW-1:0] raddr;
    } t_gmem_req;

    typedef struct packed {
        logic           we;
        logic [KAW-1:0] waddr;
        t_kern_ent      wdata;
        logic [KAW-1:0] raddr;
    } t_kmem_req;

    typedef enum logic [2:0] {
        S_IDLE   = 3'd0,
        S_SEARCH = 3'd1,
        S_GREAD  = 3'd2,
        S_GWAIT  = 3'd3,
        S_KERN   = 3'd4,
        S_KWAIT  = 3'd5,
        S_OUT    = 3'd6
    } t_state;

endpackage

// File: hw/rtl/glk_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing.
module glk_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 48,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/glk_seq.sv
// Sequencer of the glyph lookup: table loads, linear code search, kern walk.
// Depends on glk_pkg; drives the glyph and kern RAM ports.
module glk_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  glk_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output glk_pkg::t_out_item  o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [8:0]          i_cfg_data,
    output glk_pkg::t_gmem_req  o_gmem,
    input  glk_pkg::t_glyph_ent i_grdata,
    output glk_pkg::t_kmem_req  o_kmem,
    input  glk_pkg::t_kern_ent  i_krdata
);
    import glk_pkg::*;

    t_state             r_state, n_state;
    logic [8:0]         r_num, n_num;
    logic               r_pt, n_pt;
    logic [10:0]        r_prev, n_prev;
    logic [15:0]        r_code, n_code;
    logic [CNT_W-1:0]   r_idx, n_idx;
    logic               r_pend, n_pend;
    logic [CNT_W-1:0]   r_pidx, n_pidx;
    logic [15:0]        r_gid, n_gid;
    logic [10:0]        r_g, n_g;
    logic [15:0]        r_adv, n_adv;
    logic [15:0]        r_k, n_k;
    logic signed [15:0] r_adj, n_adj;
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out, n_out;

    logic [CNT_W-1:0]   usable;

    // Mask is applied by the caller; zero when at or above the usable count.
    function automatic logic [10:0] clamp_glyph(input logic [10:0] g,
                                                input logic [CNT_W-1:0] lim);
        return ({1'b0, g} >= lim) ? 11'd0 : g;
    endfunction

    assign usable = (CNT_W'(r_num) < CNT_W'(GLYPH_ENTRIES)) ? CNT_W'(r_num)
                                                           : CNT_W'(GLYPH_ENTRIES);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_num       <= '0;
            r_pt        <= 1'b0;
            r_prev      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_num       <= n_num;
            r_pt        <= n_pt;
            r_prev      <= n_prev;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
        r_code <= n_code;
        r_idx  <= n_idx;
        r_pidx <= n_pidx;
        r_gid  <= n_gid;
        r_g    <= n_g;
        r_adv  <= n_adv;
        r_k    <= n_k;
        r_adj  <= n_adj;
        r_out  <= n_out;
    end

    always_comb begin
        logic pt_now;
        pt_now      = r_pt;
        n_state     = r_state;
        n_num       = r_num;
        n_pt        = r_pt;
        n_prev      = r_prev;
        n_code      = r_code;
        n_idx       = r_idx;
        n_pend      = 1'b0;
        n_pidx      = r_pidx;
        n_gid       = r_gid;
        n_g         = r_g;
        n_adv       = r_adv;
        n_k         = r_k;
        n_adj       = r_adj;
        n_out       = r_out;
        n_out_valid = r_out_valid;

        o_gmem.we           = 1'b0;
        o_gmem.waddr        = i_in_data.entry_index[GAW-1:0];
        o_gmem.wdata.code   = i_in_data.char_code;
        o_gmem.wdata.width  = i_in_data.glyph_width;
        o_gmem.wdata.kstart = i_in_data.kern_list_start;
        o_gmem.raddr        = r_idx[GAW-1:0];
        o_kmem.we           = 1'b0;
        o_kmem.waddr        = i_in_data.entry_index[KAW-1:0];
        o_kmem.wdata.first  = i_in_data.pair_first;
        o_kmem.wdata.second = i_in_data.pair_second;
        o_kmem.wdata.adjust = i_in_data.pair_adjust;
        o_kmem.raddr        = r_k[KAW-1:0];

        if (i_cfg_valid) begin
            n_num = i_cfg_data;
        end
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    priority if (i_in_data.mode == MODE_GLYPH) begin
                        o_gmem.we = 32'(i_in_data.entry_index) < GLYPH_ENTRIES;
                    end else if (i_in_data.mode == MODE_KERN) begin
                        o_kmem.we = 32'(i_in_data.entry_index) < KERN_ENTRIES;
                    end else if (i_in_data.mode == MODE_TEXT) begin
                        if (i_in_data.string_start) begin
                            pt_now = (i_in_data.char_code == 16'd0) ||
                                     ((i_in_data.char_code & TOP_BITS) == TOP_BITS);
                            n_prev = '0;
                        end
                        n_pt   = pt_now;
                        n_code = i_in_data.char_code;
                        n_idx  = '0;
                        if (pt_now) begin
                            n_gid   = i_in_data.char_code;
                            n_g     = clamp_glyph(i_in_data.char_code[10:0], usable);
                            n_state = S_GREAD;
                        end else begin
                            n_state = S_SEARCH;
                        end
                    end else begin
                        // unused mode: dropped
                    end
                end
            end
            S_SEARCH: begin
                if (r_pend && (i_grdata.code == r_code)) begin
                    n_gid   = 16'(r_pidx);
                    n_g     = clamp_glyph(r_pidx[10:0], usable);
                    n_state = S_GREAD;
                end else if (r_idx < usable) begin
                    n_pend = 1'b1;
                    n_pidx = r_idx;
                    n_idx  = r_idx + CNT_W'(1);
                end else if (!r_pend) begin
                    n_gid   = '0;
                    n_g     = '0;
                    n_state = S_GREAD;
                end
            end
            S_GREAD: begin
                o_gmem.raddr = r_g[GAW-1:0];
                n_state      = S_GWAIT;
            end
            S_GWAIT: begin
                n_adv   = i_grdata.width;
                n_k     = i_grdata.kstart;
                n_adj   = '0;
                n_state = (r_prev == 11'd0) ? S_OUT : S_KERN;
            end
            S_KERN: begin
                if ((r_k == LIST_END) || (32'(r_k) >= KERN_ENTRIES)) begin
                    n_state = S_OUT;
                end else begin
                    n_k     = r_k + 16'd1;
                    n_state = S_KWAIT;
                end
            end
            S_KWAIT: begin
                if ((i_krdata.first == LIST_END) || (i_krdata.second != {5'd0, r_g})) begin
                    n_state = S_OUT;
                end else if (i_krdata.first == {5'd0, r_prev}) begin
                    n_adj   = i_krdata.adjust;
                    n_state = S_OUT;
                end else begin
                    n_state = S_KERN;
                end
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid       = 1'b1;
                    n_out.glyph_id    = r_gid;
                    n_out.advance     = r_adv;
                    n_out.kern_adjust = r_adj;
                    n_prev            = r_gid[10:0];
                    n_state           = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

endmodule

// File: hw/rtl/glyph_lookup_and_kern.sv
// Top level of the glyph lookup and kerning block.
// Depends on glk_pkg, glk_ram (glyph and kern tables) and glk_seq.
//
// Load items (mode 0 glyph entry, mode 1 kern pair) are written in the cycle
// they transfer. A text item (mode 2) searches the glyph table linearly,
// one entry per cycle through the single read port of the glyph RAM, over
// at most min(num_glyphs, 256) entries (no search when the code passes
// through), then reads the found glyph's width and kern list start, then
// walks the kern list pair by pair through the kern RAM read port, and
// last loads the output register. The input side is stalled while a text
// item is in work; a finished result sits in the output register, so the
// next item transfers while it waits. Table entries must be written
// before they are read; the user must write num_glyphs through the cfg
// port only while the block is idle, which the block itself does not
// enforce, and that port is always ready.
module glyph_lookup_and_kern (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  glk_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output glk_pkg::t_out_item o_out_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [8:0]         i_cfg_data
);
    import glk_pkg::*;

    t_gmem_req  gmem;
    t_kmem_req  kmem;
    t_glyph_ent grdata;
    t_kern_ent  krdata;

    // Glyph table: code, width and kern list start in one word.
    glk_ram #(
        .DEPTH (GLYPH_ENTRIES),
        .WIDTH ($bits(t_glyph_ent))
    ) u_glyph_ram (
        .i_clk   (i_clk),
        .i_we    (gmem.we),
        .i_waddr (gmem.waddr),
        .i_wdata (gmem.wdata),
        .i_raddr (gmem.raddr),
        .o_rdata (grdata)
    );

    // Kern pair table: first glyph, second glyph, signed adjustment.
    glk_ram #(
        .DEPTH (KERN_ENTRIES),
        .WIDTH ($bits(t_kern_ent))
    ) u_kern_ram (
        .i_clk   (i_clk),
        .i_we    (kmem.we),
        .i_waddr (kmem.waddr),
        .i_wdata (kmem.wdata),
        .i_raddr (kmem.raddr),
        .o_rdata (krdata)
    );

    // Sequencer: handshakes, config register, search and kern walk.
    glk_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_gmem      (gmem),
        .i_grdata    (grdata),
        .o_kmem      (kmem),
        .i_krdata    (krdata)
    );

endmodule

// File: hw/rtl/glk_checker.sv
// Port-level checks of the glyph lookup and kerning block, bound to its top.
// Depends on glk_pkg and glyph_lookup_and_kern.
module glk_port_checks (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input glk_pkg::t_in_item  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input glk_pkg::t_out_item o_out_data,
    input logic               i_cfg_valid,
    input logic               o_cfg_ready,
    input logic [8:0]         i_cfg_data
);
    import glk_pkg::*;

    logic in_xfer;
    assign in_xfer = i_in_valid && !o_in_stall;

    // A text transfer starts a search or, for a passthrough code, a glyph read: the input side is busy next cycle.
    a_text_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && (i_in_data.mode == MODE_TEXT)) |=> o_in_stall)
        else $error("input not stalled after text transfer");

    // Loads and unused modes finish in their own cycle.
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && ((i_in_data.mode == MODE_GLYPH) || (i_in_data.mode == MODE_KERN) ||
                     (i_in_data.mode == MODE_NONE))) |=> !o_in_stall)
        else $error("input stalled after load transfer");

    // A new result only comes out of a busy sequencer.
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without work in progress");

    // A stalled result stays and holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result dropped or changed");

endmodule

bind glyph_lookup_and_kern glk_port_checks u_glk_port_checks (.*);

// File: test/glk_checker.sv
// Result checker for glyph_lookup_and_kern: mirrors the glyph and kern tables,
// predicts every text result and compares it with what the block delivers.
// Depends on glk_pkg for the payload types and table sizes.
module glk_checker
    import glk_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_item  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_item i_out_data,
    input  logic      i_cfg_valid,
    input  logic      i_cfg_ready,
    input  logic [8:0] i_cfg_data,
    output int        o_fail_count,
    output int        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [15:0] code_tab   [GLYPH_ENTRIES];
    logic [15:0] width_tab  [GLYPH_ENTRIES];
    logic [15:0] kstart_tab [GLYPH_ENTRIES];
    t_kern_ent   pair_tab   [KERN_ENTRIES];
    logic [10:0] prev_glyph = '0;
    logic        pass_mode = 1'b0;
    logic [8:0]  glyph_count = '0;
    t_out_item   glyph_results_due [$];
    int          fails = 0;

    function automatic int unsigned live_glyphs();
        return (glyph_count < GLYPH_ENTRIES) ? int'(glyph_count) : GLYPH_ENTRIES;
    endfunction

    // first matching entry wins, unknown code maps to glyph 0
    function automatic logic [15:0] search_glyph(input logic [15:0] code);
        int unsigned n;
        n = live_glyphs();
        for (int unsigned i = 0; i < n; i++) begin
            if (code_tab[i] == code) begin
                return 16'(i);
            end
        end
        return 16'd0;
    endfunction

    function automatic logic signed [15:0] pair_kerning(input int unsigned g,
                                                        input int unsigned prev);
        int unsigned k;
        int unsigned e;
        if (prev == 0) begin
            return 16'sd0;
        end
        k = kstart_tab[g];
        while (k != LIST_END && k < KERN_ENTRIES) begin
            e = k;
            k++;
            if (pair_tab[e].first == LIST_END || pair_tab[e].second != g) begin
                break;
            end
            if (pair_tab[e].first == prev) begin
                return pair_tab[e].adjust;
            end
        end
        return 16'sd0;
    endfunction

    task automatic predict_text(input t_in_item it);
        t_out_item   r;
        logic [15:0] gid;
        int unsigned g;
        if (it.string_start) begin
            pass_mode  = (it.char_code == 16'd0) || ((it.char_code & TOP_BITS) == TOP_BITS);
            prev_glyph = '0;
        end
        gid = pass_mode ? it.char_code : search_glyph(it.char_code);
        g = gid[10:0];
        if (g >= live_glyphs() || g >= GLYPH_ENTRIES) begin
            g = 0;
        end
        r.glyph_id    = gid;
        r.advance     = width_tab[g];
        r.kern_adjust = pair_kerning(g, prev_glyph);
        glyph_results_due.push_back(r);
        prev_glyph = gid[10:0];
    endtask

    task automatic take_item(input t_in_item it);
        case (it.mode)
            MODE_GLYPH: begin
                if (it.entry_index < GLYPH_ENTRIES) begin
                    code_tab[it.entry_index]   = it.char_code;
                    width_tab[it.entry_index]  = it.glyph_width;
                    kstart_tab[it.entry_index] = it.kern_list_start;
                end
            end
            MODE_KERN: begin
                if (it.entry_index < KERN_ENTRIES) begin
                    pair_tab[it.entry_index] = {it.pair_first, it.pair_second, it.pair_adjust};
                end
            end
            MODE_TEXT: begin
                predict_text(it);
            end
            default: begin
            end
        endcase
    endtask

    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (glyph_results_due.size() == 0) begin
            $display("%0t: unexpected result glyph_id %h advance %h kern_adjust %0d",
                     $time, got.glyph_id, got.advance, got.kern_adjust);
            fails++;
        end else begin
            want = glyph_results_due.pop_front();
            if (got.glyph_id !== want.glyph_id) begin
                $display("%0t: glyph_id expected %h actual %h",
                         $time, want.glyph_id, got.glyph_id);
                fails++;
            end
            if (got.advance !== want.advance) begin
                $display("%0t: advance expected %h actual %h",
                         $time, want.advance, got.advance);
                fails++;
            end
            if (got.kern_adjust !== want.kern_adjust) begin
                $display("%0t: kern_adjust expected %0d actual %0d",
                         $time, want.kern_adjust, got.kern_adjust);
                fails++;
            end
        end
    endtask

    // outputs first: a result can never belong to an item taken on the same edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            glyph_results_due.delete();
            prev_glyph  = '0;
            pass_mode   = 1'b0;
            glyph_count = '0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                check_result(i_out_data);
            end
            if (i_cfg_valid && i_cfg_ready) begin
                glyph_count = i_cfg_data;
            end
            if (i_in_valid && !i_in_stall) begin
                take_item(i_in_data);
            end
        end
        o_fail_count <= fails;
        o_pending    <= glyph_results_due.size();
    end

endmodule

// File: test/testbench.sv
// Top of the glyph_lookup_and_kern testbench: clock, reset, stimulus and verdict.
// Depends on glk_pkg, the block itself and glk_checker, which checks the results.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import glk_pkg::*;

    // Longest legal quiet stretch is one text item walking the whole pair
    // table plus a receiver stall; this limit is set well above that.
    localparam int QUIET_LIMIT   = 20000;
    // Loads finish as they transfer, so a short settle covers them before a cfg write.
    localparam int SETTLE_CYCLES = 16;
    // After the last result: room for a full search plus a long kern walk.
    localparam int DRAIN_CYCLES  = 3000;
    localparam int PHASE_ITEMS   = 90;
    localparam int NUM_PHASES    = 8;
    // Pair entries at the very end of the table, walked off the end by glyph 7.
    localparam int TAIL_PAIRS    = 4;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_item  in_data = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_data;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic [8:0] cfg_data = '0;
    int        fail_count;
    int        pending;

    // Stimulus-side copy of the font, only used to pick meaningful codes.
    logic [15:0] font_code   [GLYPH_ENTRIES];
    logic [15:0] font_kstart [GLYPH_ENTRIES];
    t_kern_ent   font_pairs  [KERN_ENTRIES];
    int          cur_glyphs = 0;
    int          burst_left = 0;
    // Pair entries 0 .. pairs_used-1 are loaded; the last of them is a list end.
    int          pairs_used = 0;

    // num_glyphs per random phase: extremes, tiny alphabets, and one random pick
    int phase_glyphs [NUM_PHASES] = '{16, 0, 511, 1, 255, 8, 256, 0};

    glyph_lookup_and_kern i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    glk_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    // Receiver back-pressure: switches between free flow, coin-flip stalls,
    // mostly-stalled and a fixed periodic pattern, each held for a random stretch.
    int          stall_mode = 0;
    int          stall_left = 0;
    int unsigned beat = 0;

    always @(posedge clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 200);
        end
        stall_left--;
        beat++;
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= 1'($urandom_range(0, 1));
            2:       out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= ((beat % 5) < 2);
        endcase
    end

    // Watchdog: any transfer on any channel counts as progress.
    int quiet_cycles = 0;

    always @(posedge clk) begin
        if (!rst_n) begin
            quiet_cycles = 0;
        end else if ((in_valid && !in_stall) || (out_valid && !out_stall)
                     || (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // All fields random so unused ones toggle too; callers then shape the item.
    function automatic t_in_item noise_item();
        logic [127:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom};
        return raw[$bits(t_in_item)-1:0];
    endfunction

    // Preceding glyph of a pair: mostly small glyphs so kerning hits in the
    // small-alphabet phases, now and then any glyph or any 16-bit value.
    function automatic logic [15:0] pick_pair_first();
        case ($urandom_range(0, 7))
            0:       return 16'($urandom);
            1:       return 16'($urandom_range(0, 255));
            default: return 16'($urandom_range(1, 15));
        endcase
    endfunction

    function automatic logic [15:0] pick_text_code();
        int usable;
        usable = (cur_glyphs < GLYPH_ENTRIES) ? cur_glyphs : GLYPH_ENTRIES;
        if (usable > 0 && $urandom_range(0, 3) != 0) begin
            return font_code[$urandom_range(0, usable - 1)];
        end
        return 16'($urandom);
    endfunction

    // One transfer. Called at a rising edge, returns at the edge it was taken.
    // Bursts of random length, random gaps in between; valid only drops in a gap.
    task automatic send(input t_in_item it);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic send_text(input logic [15:0] code, input logic first);
        t_in_item it;
        it = noise_item();
        it.mode         = MODE_TEXT;
        it.char_code    = code;
        it.string_start = first;
        send(it);
    endtask

    // Sender holds off until every result is in; the extra edge lets the
    // checker's count take in the item that was just transferred.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_glyph_count(input int n);
        wait_idle();
        cfg_valid  <= 1'b1;
        cfg_data   <= 9'(n);
        cur_glyphs = n;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Lay out a font and load every glyph entry and every pair entry that a
    // kern walk can reach, so nothing read later is ever unwritten. Glyph 1
    // gets a fixed two-pair list (extreme adjustments) for the directed
    // kerning checks; the low glyphs get short lists, none, or a start past
    // the table; some lists and the packed region close with a list end. Glyph 7
    // gets a list in the last few entries that runs off the end of the pair table.
    task automatic build_font();
        int       p;
        int       len;
        t_in_item it;
        for (int i = 0; i < GLYPH_ENTRIES; i++) begin
            // low byte is the index, high byte never 0xF8+ : distinct, no passthrough
            font_code[i] = {8'($urandom_range(1, 247)), 8'(i)};
        end
        font_pairs[0]  = {16'd2, 16'd1, 16'h8000};
        font_pairs[1]  = {16'd3, 16'd1, 16'h7FFF};
        font_pairs[2]  = {LIST_END, 16'($urandom), 16'($urandom)};
        font_kstart[1] = 16'd0;
        p = 3;
        for (int g = 0; g < GLYPH_ENTRIES; g++) begin
            if (g != 1) begin
                case ($urandom_range(0, 7))
                    0: font_kstart[g] = LIST_END;
                    1: font_kstart[g] = 16'($urandom_range(KERN_ENTRIES, 65534));
                    default: begin
                        if (p >= 190) begin
                            font_kstart[g] = LIST_END;
                        end else begin
                            font_kstart[g] = 16'(p);
                            len = $urandom_range(1, 6);
                            repeat (len) begin
                                font_pairs[p] = {pick_pair_first(), 16'(g), 16'($urandom)};
                                p = p + 1;
                            end
                            if ($urandom_range(0, 1) == 1) begin
                                font_pairs[p] = {LIST_END, 16'($urandom), 16'($urandom)};
                                p = p + 1;
                            end
                        end
                    end
                endcase
            end
        end
        font_pairs[p] = {LIST_END, 16'($urandom), 16'($urandom)};
        p = p + 1;
        pairs_used = p;
        font_kstart[7] = 16'(KERN_ENTRIES - TAIL_PAIRS);
        for (int i = KERN_ENTRIES - TAIL_PAIRS; i < KERN_ENTRIES; i++) begin
            font_pairs[i] = {pick_pair_first(), 16'd7, 16'($urandom)};
        end

        for (int i = 0; i < GLYPH_ENTRIES; i++) begin
            it = noise_item();
            it.mode            = MODE_GLYPH;
            it.entry_index     = 10'(i);
            it.char_code       = font_code[i];
            it.kern_list_start = font_kstart[i];
            send(it);
        end
        for (int i = 0; i < KERN_ENTRIES; i++) begin
            if (i >= p && i < KERN_ENTRIES - TAIL_PAIRS) begin
                continue;
            end
            it = noise_item();
            it.mode        = MODE_KERN;
            it.entry_index = 10'(i);
            it.pair_first  = font_pairs[i].first;
            it.pair_second = font_pairs[i].second;
            it.pair_adjust = font_pairs[i].adjust;
            send(it);
        end
    endtask

    task automatic directed_items();
        t_in_item it;
        // no string started since reset: codes are searched
        send_text(font_code[3], 1'b0);
        // kerning hit on the first pair, then on the second pair of a list
        send_text(font_code[2], 1'b1);
        send_text(font_code[1], 1'b0);
        send_text(font_code[3], 1'b1);
        send_text(font_code[1], 1'b0);
        // previous glyph 0 never kerns
        send_text(font_code[0], 1'b1);
        send_text(font_code[1], 1'b0);
        // just below the passthrough pattern: searched, not found
        send_text(16'hF7FF, 1'b1);
        send_text(16'hFFFF, 1'b0);
        // code 0 starts a passthrough string; masked glyph clamps at or above num_glyphs
        send_text(16'h0000, 1'b1);
        send_text(16'hFFFF, 1'b0);
        send_text(16'h0102, 1'b0);
        send_text(16'h00FF, 1'b0);
        // top bits all set also start passthrough
        send_text(16'hF800, 1'b1);
        send_text(font_code[1], 1'b0);
        // mode 3 is dropped
        it = '1;
        it.mode = MODE_NONE;
        send(it);
        // glyph writes past the table are dropped
        it = noise_item();
        it.mode        = MODE_GLYPH;
        it.entry_index = 10'h3FF;
        send(it);
        it.entry_index = 10'(GLYPH_ENTRIES);
        send(it);
        // last pair entry becomes a list end
        it = noise_item();
        it.mode        = MODE_KERN;
        it.entry_index = 10'h3FF;
        it.pair_first  = LIST_END;
        it.pair_second = LIST_END;
        send(it);
        // duplicate code in the last entry: the search keeps the first match
        it = noise_item();
        it.mode            = MODE_GLYPH;
        it.entry_index     = 10'(GLYPH_ENTRIES - 1);
        it.char_code       = font_code[4];
        it.kern_list_start = 16'd0;
        font_code[GLYPH_ENTRIES - 1] = font_code[4];
        send(it);
        send_text(font_code[4], 1'b1);
    endtask

    // Mostly text strings over the live glyphs, with table rewrites,
    // dropped mode 3 items and the odd passthrough string mixed in.
    // Rewrites stay inside the loaded pair entries and keep the closing list end.
    task automatic random_item(output t_in_item it);
        int roll;
        it   = noise_item();
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
            it.mode = MODE_GLYPH;
            it.entry_index = ($urandom_range(0, 4) != 0) ? 10'($urandom_range(0, 255))
                                                         : 10'($urandom_range(256, 1023));
            if ($urandom_range(0, 1) == 1) begin
                it.char_code = font_code[$urandom_range(0, GLYPH_ENTRIES - 1)];
            end
            case ($urandom_range(0, 9))
                0, 1:    it.kern_list_start = LIST_END;
                2:       it.kern_list_start = 16'($urandom_range(KERN_ENTRIES, 65534));
                default: it.kern_list_start = 16'($urandom_range(0, pairs_used - 1));
            endcase
            if (it.entry_index < GLYPH_ENTRIES) begin
                font_code[it.entry_index] = it.char_code;
            end
        end else if (roll < 16) begin
            it.mode = MODE_KERN;
            it.entry_index = 10'($urandom_range(0, pairs_used - 2));
            it.pair_first = ($urandom_range(0, 9) == 0) ? LIST_END : pick_pair_first();
            if ($urandom_range(0, 9) < 7) begin
                it.pair_second = 16'($urandom_range(0, 15));
            end
        end else if (roll < 19) begin
            it.mode = MODE_NONE;
        end else begin
            it.mode         = MODE_TEXT;
            it.string_start = ($urandom_range(0, 5) == 0);
            if (it.string_start) begin
                case ($urandom_range(0, 9))
                    0:       it.char_code = 16'h0000;
                    1:       it.char_code = {5'h1F, 11'($urandom)};
                    default: it.char_code = pick_text_code();
                endcase
            end else begin
                it.char_code = pick_text_code();
            end
        end
    endtask

    initial begin
        t_in_item it;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        set_glyph_count(GLYPH_ENTRIES);
        build_font();
        directed_items();

        // every cfg write below also drains all results first
        phase_glyphs[NUM_PHASES - 1] = $urandom_range(2, 300);
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            set_glyph_count(phase_glyphs[ph]);
            repeat (PHASE_ITEMS) begin
                random_item(it);
                send(it);
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// File: files.f
hw/rtl/glk_pkg.sv
hw/rtl/glk_ram.sv
hw/rtl/glk_seq.sv
hw/rtl/glyph_lookup_and_kern.sv
hw/rtl/glk_checker.sv
test/glk_checker.sv
test/testbench.sv
